>>> design/shsc_pkg.sv
// Package for the sprocket hole step controller.
// Holds the stream widths, register map, reset values and result codes.
// It has no dependencies. The top level imports it.
package shsc_pkg;

  // Stream payload widths. Fields are packed from the lowest bit up, and
  // the packed tdata width is rounded up to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 48;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes. The word index is paddr[2].
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;
  localparam logic REG_DRIVE_PERCENT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [6:0]  DRIVE_RESET   = 7'd100;
  localparam logic [6:0]  DRIVE_MAX     = 7'd100;
  localparam logic [15:0] MISALIGN_MAX  = 16'hFFFF;

  // Which wait phase, if any, timed out in this tick.
  typedef enum logic [1:0] {
    TO_NONE  = 2'd0,
    TO_SEEK  = 2'd1,
    TO_LEAVE = 2'd2,
    TO_REACH = 2'd3
  } timeout_code_t;

endpackage

>>> design/sprocket_hole_step_controller_top.sv
// Sprocket hole step controller, top level.
// Latency: a result is valid in the cycle after its tick transaction is accepted.
// Throughput: one tick per clock while out_tready is high. The output register frees
// in_tready in the same cycle that out_tready takes the pending result.
// Reset (rst_n, synchronous, active low): start phase, empty request queue,
// zero counters, timeout_limit = 5000, drive_percent = 100.
// Depends on shsc_pkg.
module sprocket_hole_step_controller_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Tick input.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] sensor_high, [8:1] request_steps, [15:9] zero
  input  logic [shsc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] request_valid
  input  logic [shsc_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Result output.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] motor_drive, [8] busy_res, [16:9] steps_left, [18:17] timeout_code,
  // [34:19] misalign_count, [35] request_dropped, [40:36] queue_level, [47:41] zero
  output logic [shsc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [shsc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [shsc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [shsc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import shsc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_START,
    PH_SEEK,
    PH_CHECK,
    PH_WAIT,
    PH_LEAVE,
    PH_REACH
  } phase_t;

  // Configuration registers.
  logic [15:0] timeout_limit_r;
  logic [6:0]  drive_percent_r;
  logic        cfg_wr;

  // Controller state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] mis_r, mis_nxt;

  // Request queue.
  logic [7:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt, head_sel;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_push;
  logic [7:0]       rd_data_r;
  logic             byp_r;
  logic [7:0]       byp_data_r;
  logic [7:0]       head_val;
  logic             wr_en;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Tick fields.
  logic       in_acc;
  logic       sensor;
  logic       req;
  logic [7:0] req_steps;

  // Per-tick results.
  logic          push;
  logic          dropped;
  logic          acted;
  logic [7:0]    rem_step;
  timeout_code_t code;
  logic [6:0]    dp;
  logic [7:0]    drive;
  logic          busy;
  logic [7:0]    steps_out;

  assign sensor    = in_tdata[0];
  assign req_steps = in_tdata[8:1];
  assign req       = in_tuser[0];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    if (cfg_paddr[2] == REG_DRIVE_PERCENT) begin
      cfg_prdata = {{(CFG_DATA_W - 7){1'b0}}, drive_percent_r};
    end else begin
      cfg_prdata = {{(CFG_DATA_W - 16){1'b0}}, timeout_limit_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_RESET;
      drive_percent_r <= DRIVE_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TIMEOUT_LIMIT) begin
        timeout_limit_r <= cfg_pwdata[15:0];
      end else begin
        drive_percent_r <= cfg_pwdata[6:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic for one tick
  // ---------------------------------------------------------------------------
  assign push     = req && (cnt_r < CNT_FULL);
  assign dropped  = req && !push;
  assign cnt_push = cnt_r + CNT_W'(push);
  assign wr_en    = in_acc && push;

  // With an empty queue the only entry can be this tick's own request.
  assign head_val = (cnt_r == '0) ? req_steps : (byp_r ? byp_data_r : rd_data_r);

  // Remaining steps after one finished hole: toward zero by one.
  always_comb begin
    if (rem_r[7]) begin
      rem_step = rem_r + 8'd1;
    end else if (rem_r != 8'd0) begin
      rem_step = rem_r - 8'd1;
    end else begin
      rem_step = rem_r;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    wait_nxt  = wait_r;
    mis_nxt   = mis_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_push;
    code      = TO_NONE;
    acted     = 1'b0;

    if (push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
    end

    case (phase_r)
      PH_START: begin
        if (sensor) begin
          wait_nxt  = timeout_limit_r;
          phase_nxt = PH_SEEK;
          acted     = 1'b1;
        end else begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_SEEK: begin
        acted = 1'b1;
        if (!sensor) begin
          phase_nxt = PH_CHECK;
        end else if (wait_r == 16'd0) begin
          code      = TO_SEEK;
          phase_nxt = PH_CHECK;
        end else begin
          wait_nxt = wait_r - 16'd1;
        end
      end
      PH_LEAVE: begin
        acted = 1'b1;
        if (sensor) begin
          wait_nxt  = timeout_limit_r;
          phase_nxt = PH_REACH;
        end else if (wait_r == 16'd0) begin
          code      = TO_LEAVE;
          wait_nxt  = timeout_limit_r;
          phase_nxt = PH_REACH;
        end else begin
          wait_nxt = wait_r - 16'd1;
        end
      end
      PH_REACH: begin
        acted = 1'b1;
        if (!sensor || wait_r == 16'd0) begin
          if (sensor) begin
            code = TO_REACH;
          end
          rem_nxt = rem_step;
          if (rem_step != 8'd0) begin
            wait_nxt  = timeout_limit_r;
            phase_nxt = PH_LEAVE;
          end else begin
            phase_nxt = PH_CHECK;
          end
        end else begin
          wait_nxt = wait_r - 16'd1;
        end
      end
      default: begin
      end
    endcase

    // Idle path: misalignment check, then take the next request if any.
    if (!acted) begin
      if (phase_nxt == PH_CHECK) begin
        if (sensor && mis_r != MISALIGN_MAX) begin
          mis_nxt = mis_r + 16'd1;
        end
        phase_nxt = PH_WAIT;
      end
      if (phase_nxt == PH_WAIT && cnt_push != '0) begin
        rem_nxt  = head_val;
        head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        cnt_nxt  = cnt_push - CNT_W'(1);
        if (head_val != 8'd0) begin
          wait_nxt  = timeout_limit_r;
          phase_nxt = PH_LEAVE;
        end else begin
          phase_nxt = PH_CHECK;
        end
      end
    end
  end

  // Result fields from the state after the tick.
  assign dp = (drive_percent_r > DRIVE_MAX) ? DRIVE_MAX : drive_percent_r;

  always_comb begin
    drive = 8'd0;
    busy  = 1'b0;
    case (phase_nxt)
      PH_SEEK: begin
        drive = {1'b0, dp};
        busy  = 1'b1;
      end
      PH_LEAVE, PH_REACH: begin
        drive = rem_nxt[7] ? (8'd0 - {1'b0, dp}) : {1'b0, dp};
        busy  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign steps_out = busy ? rem_nxt : 8'd0;

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      rem_r   <= 8'd0;
      wait_r  <= 16'd0;
      mis_r   <= 16'd0;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      wait_r  <= wait_nxt;
      mis_r   <= mis_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Queue memory. The next head entry is registered in advance from head_sel; an entry written in
  // the same cycle as it becomes the head is taken from the bypass register.
  assign head_sel = in_acc ? head_nxt : head_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= req_steps;
    end
    rd_data_r  <= mem[head_sel];
    byp_data_r <= req_steps;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (tail_r == head_sel);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {7'd0, 5'(cnt_nxt), dropped, mis_nxt, code, steps_out, busy, drive};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("request queue count exceeds depth");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (cnt_r == '0 || cnt_r == CNT_FULL))
    else $error("queue pointers disagree with count");

  a_move_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEAVE || phase_r == PH_REACH) |-> (rem_r != 8'd0))
    else $error("step move active with no steps left");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_acc)
    else $error("pending result overwritten");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sprocket hole step controller top level.
// Drives tick transactions and APB register writes, predicts every result in
// a local model of the controller and compares it field by field. Needs shsc_pkg.
module tb_top;
  import shsc_pkg::*;

  localparam int QDEPTH = 16;

  // Controller modes as the prediction tracks them.
  typedef enum logic [2:0] {
    CM_START, CM_SEEK, CM_CHECK, CM_IDLE, CM_LEAVE, CM_REACH
  } ctl_mode_t;

  typedef struct packed {
    logic       sensor;
    logic       req;
    logic [7:0] steps;
  } tick_t;

  typedef struct packed {
    logic [7:0]    drive;
    logic          busy;
    logic [7:0]    steps_left;
    timeout_code_t code;
    logic [15:0]   misalign;
    logic          dropped;
    logic [4:0]    level;
  } hole_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  sprocket_hole_step_controller_top #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Local copy of the controller state and its registers.
  ctl_mode_t   mode = CM_START;
  logic [7:0]  steps_rem = '0;
  logic [15:0] wait_left = '0;
  logic [15:0] misalign_cnt = '0;
  logic [7:0]  step_queue[$];
  logic [15:0] timeout_cfg = TIMEOUT_RESET;
  logic [6:0]  drive_cfg = DRIVE_RESET;

  tick_t        pending_ticks[$];
  hole_result_t expected_results[$];
  tick_t        cur_tick;

  int mismatches = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int drops_seen = 0;
  int peak_level = 0;
  int timeouts_seen[4] = '{0, 0, 0, 0};
  int idle_pct = 0;
  int hold_len = 0;
  int tx_gap = 0;
  int rx_stall = 0;

  function automatic hole_result_t predict_tick(input tick_t t);
    hole_result_t r;
    logic         acted;
    logic [6:0]   mag;
    r = '0;
    r.code = TO_NONE;
    acted = 1'b0;
    if (t.req) begin
      if (step_queue.size() >= QDEPTH) r.dropped = 1'b1;
      else step_queue.push_back(t.steps);
    end
    case (mode)
      CM_START: begin
        if (t.sensor) begin
          wait_left = timeout_cfg;
          mode = CM_SEEK;
          acted = 1'b1;
        end else begin
          mode = CM_CHECK;
        end
      end
      CM_SEEK: begin
        acted = 1'b1;
        if (!t.sensor) begin
          mode = CM_CHECK;
        end else if (wait_left == 16'd0) begin
          r.code = TO_SEEK;
          mode = CM_CHECK;
        end else begin
          wait_left = wait_left - 16'd1;
        end
      end
      CM_LEAVE: begin
        acted = 1'b1;
        if (t.sensor || wait_left == 16'd0) begin
          if (!t.sensor) r.code = TO_LEAVE;
          wait_left = timeout_cfg;
          mode = CM_REACH;
        end else begin
          wait_left = wait_left - 16'd1;
        end
      end
      CM_REACH: begin
        acted = 1'b1;
        if (!t.sensor || wait_left == 16'd0) begin
          // A timed-out reach still counts the step as done.
          if (t.sensor) r.code = TO_REACH;
          if (steps_rem[7]) steps_rem = steps_rem + 8'd1;
          else if (steps_rem != 0) steps_rem = steps_rem - 8'd1;
          if (steps_rem != 0) begin
            wait_left = timeout_cfg;
            mode = CM_LEAVE;
          end else begin
            mode = CM_CHECK;
          end
        end else begin
          wait_left = wait_left - 16'd1;
        end
      end
      default: ;
    endcase
    if (!acted) begin
      if (mode == CM_CHECK) begin
        if (t.sensor && misalign_cnt != MISALIGN_MAX) misalign_cnt = misalign_cnt + 16'd1;
        mode = CM_IDLE;
      end
      if (mode == CM_IDLE && step_queue.size() != 0) begin
        steps_rem = step_queue.pop_front();
        if (steps_rem != 0) begin
          wait_left = timeout_cfg;
          mode = CM_LEAVE;
        end else begin
          mode = CM_CHECK;
        end
      end
    end
    mag = (drive_cfg > DRIVE_MAX) ? DRIVE_MAX : drive_cfg;
    if (mode == CM_SEEK) begin
      r.drive = {1'b0, mag};
      r.busy = 1'b1;
    end else if (mode == CM_LEAVE || mode == CM_REACH) begin
      r.drive = steps_rem[7] ? 8'd0 - {1'b0, mag} : {1'b0, mag};
      r.busy = 1'b1;
      r.steps_left = steps_rem;
    end
    r.misalign = misalign_cnt;
    r.level = 5'(step_queue.size());
    return r;
  endfunction

  function automatic void check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Tick driver: one prediction per accepted transaction.
  always @(posedge clk) begin : tick_driver
    logic fire;
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        expected_results.push_back(predict_tick(cur_tick));
        ticks_sent++;
      end
      next_valid = in_tvalid && !fire;
      if (!in_tvalid || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          tx_gap = $urandom_range(0, 9);
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          next_valid = 1'b1;
          in_tdata <= {7'd0, cur_tick.steps, cur_tick.sensor};
          in_tuser <= cur_tick.req;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : result_monitor
    hole_result_t want;
    logic [OUT_TDATA_W-1:0] got;
    logic next_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual 'h%0h",
                   $time, got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("motor_drive", $signed(want.drive), $signed(got[7:0]));
          check_field("busy_res", want.busy, got[8]);
          check_field("steps_left", $signed(want.steps_left), $signed(got[16:9]));
          check_field("timeout_code", want.code, got[18:17]);
          check_field("misalign_count", want.misalign, got[34:19]);
          check_field("request_dropped", want.dropped, got[35]);
          check_field("queue_level", want.level, got[40:36]);
          check_field("tdata padding", 0, got[47:41]);
          results_checked++;
          if (want.dropped) drops_seen++;
          timeouts_seen[want.code]++;
          if (want.level > peak_level) peak_level = want.level;
        end
      end
      if (hold_len > 0) begin
        rx_stall = hold_len;
        hold_len = 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        next_ready = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        rx_stall = $urandom_range(0, 9);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_tready <= next_ready;
    end
  end

  task automatic add_tick(input logic s, input logic rq, input logic [7:0] st);
    pending_ticks.push_back(tick_t'({s, rq, st}));
  endtask

  // The sensor follows the sprocket: alternating runs of blocked and open
  // ticks, with an occasional single-tick glitch.
  task automatic add_random_ticks(input int count, input int req_pct, input int wide_pct,
                                  input int max_run);
    logic       lvl;
    int         run_left;
    logic       s;
    logic       rq;
    logic [7:0] st;
    lvl = 1'($urandom_range(0, 1));
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        lvl = !lvl;
        run_left = $urandom_range(1, max_run);
      end
      run_left--;
      s = ($urandom_range(0, 15) == 0) ? !lvl : lvl;
      rq = ($urandom_range(0, 99) < req_pct);
      if (!rq || $urandom_range(0, 99) < wide_pct) st = 8'($urandom_range(0, 255));
      else st = 8'($urandom_range(0, 8) - 4);
      add_tick(s, rq, st);
    end
  endtask

  task automatic reg_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_TIMEOUT_LIMIT) timeout_cfg = value[15:0];
    else drive_cfg = value[6:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: start tick, seek, zero request, take in same tick.
    @(negedge clk);
    add_tick(1'($urandom_range(0, 1)), 1'b0, 8'h00);
    add_tick(1'b1, 1'b1, 8'h00);
    add_tick(1'b0, 1'b0, 8'hFF);
    add_tick(1'b1, 1'b0, 8'h00);
    add_tick(1'b0, 1'b1, 8'h01);
    add_tick(1'b1, 1'b0, 8'h00);
    add_tick(1'b0, 1'b0, 8'h00);
    wait_drained();

    // Zero timeout and an over-range drive; the longest requests both ways,
    // then enough requests during the move to overflow the queue.
    reg_write(REG_TIMEOUT_LIMIT, 32'd0);
    reg_write(REG_DRIVE_PERCENT, 32'd127);
    @(negedge clk);
    add_tick(1'b0, 1'b1, 8'h7F);
    add_tick(1'b1, 1'b1, 8'h80);
    for (int i = 0; i < 16; i++) begin
      add_tick(1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 6) - 3));
    end
    wait_drained();

    reg_write(REG_DRIVE_PERCENT, 32'd0);
    @(negedge clk);
    idle_pct = 15;
    add_random_ticks(400, 20, 5, 4);
    wait_drained();

    reg_write(REG_TIMEOUT_LIMIT, 32'd3);
    reg_write(REG_DRIVE_PERCENT, 32'd55);
    @(negedge clk);
    idle_pct = 30;
    add_random_ticks(400, 10, 2, 6);
    wait_drained();

    // Longest timeout; the receiver holds off so the block stalls its input.
    reg_write(REG_TIMEOUT_LIMIT, 32'd65535);
    reg_write(REG_DRIVE_PERCENT, 32'd100);
    @(negedge clk);
    idle_pct = 10;
    add_random_ticks(300, 8, 0, 8);
    repeat (20) @(negedge clk);
    hold_len = 150;
    wait_drained();

    reg_write(REG_TIMEOUT_LIMIT, $urandom_range(0, 12));
    reg_write(REG_DRIVE_PERCENT, $urandom_range(0, 127));
    @(negedge clk);
    idle_pct = 0;
    add_random_ticks(400, 12, 3, 5);
    wait_drained();
    repeat (5) @(posedge clk);

    $display("Ran %0d ticks and checked %0d results; %0d requests dropped, peak queue level %0d.",
             ticks_sent, results_checked, drops_seen, peak_level);
    $display("Timeouts seen: seek %0d, leave hole %0d, reach hole %0d.",
             timeouts_seen[1], timeouts_seen[2], timeouts_seen[3]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
